@@ hdl/rwlm_pkg.sv @@
// ----------------------------------------------------------------------------
// rwlm_pkg
// Shared codes and types for the reader-writer lock manager.
// ----------------------------------------------------------------------------
package rwlm_pkg;

  localparam logic [2:0] CMD_READ      = 3'd0;
  localparam logic [2:0] CMD_WRITE     = 3'd1;
  localparam logic [2:0] CMD_TRY_READ  = 3'd2;
  localparam logic [2:0] CMD_TRY_WRITE = 3'd3;
  localparam logic [2:0] CMD_UNLOCK    = 3'd4;
  localparam logic [2:0] CMD_WITHDRAW  = 3'd5;

  localparam logic [2:0] ST_GRANTED    = 3'd0;
  localparam logic [2:0] ST_QUEUED     = 3'd1;
  localparam logic [2:0] ST_BUSY       = 3'd2;
  localparam logic [2:0] ST_DEADLOCK   = 3'd3;
  localparam logic [2:0] ST_INVALID    = 3'd4;
  localparam logic [2:0] ST_TIMEDOUT   = 3'd5;
  localparam logic [2:0] ST_AGAIN      = 3'd6;
  localparam logic [2:0] ST_NOTWAITING = 3'd7;

  // Controller request to the result stage.
  typedef struct packed {
    logic       push;
    logic       flush;
    logic [2:0] status;
  } rwlm_emit_t;

  // Result stage capacity back to the controller.
  typedef struct packed {
    logic room;
    logic free;
  } rwlm_room_t;

endpackage

@@ hdl/rwlm_ram.sv @@
// ----------------------------------------------------------------------------
// rwlm_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module rwlm_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/rwlm_out.sv @@
// ----------------------------------------------------------------------------
// rwlm_out
// Result staging: one pending result plus the output register, so the
// final result of a request can be tagged last once the walk has ended.
// ----------------------------------------------------------------------------
module rwlm_out
  import rwlm_pkg::*;
#(
  parameter int THREAD_ID_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rwlm_emit_t                emit,
  input  logic [THREAD_ID_BITS-1:0] emit_tid,
  output rwlm_room_t                room,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [THREAD_ID_BITS-1:0] out_thread_id_res,
  output logic [2:0]                out_status,
  output logic                      out_last
);

  logic                      pend_v_r, pend_v_nxt;
  logic [THREAD_ID_BITS-1:0] pend_tid_r;
  logic [2:0]                pend_st_r;
  logic                      out_valid_r, out_valid_nxt;
  logic [THREAD_ID_BITS-1:0] out_tid_r;
  logic [2:0]                out_st_r;
  logic                      out_last_r;
  logic                      out_free;
  logic                      move;

  assign out_free  = !out_valid_r || !out_stall;
  assign room.free = out_free;
  assign room.room = !pend_v_r || out_free;
  // push only arrives with room; flush only completes with a free output
  assign move = pend_v_r && ((emit.push) || (emit.flush && out_free));

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (move) begin
      out_valid_nxt = 1'b1;
    end
    pend_v_nxt = pend_v_r;
    if (emit.push) begin
      pend_v_nxt = 1'b1;
    end else if (emit.flush && out_free) begin
      pend_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (move) begin
      out_tid_r  <= pend_tid_r;
      out_st_r   <= pend_st_r;
      out_last_r <= emit.flush && !emit.push;
    end
    if (emit.push) begin
      pend_tid_r <= emit_tid;
      pend_st_r  <= emit.status;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_thread_id_res = out_tid_r;
  assign out_status        = out_st_r;
  assign out_last          = out_last_r;

endmodule

@@ hdl/reader_writer_lock_manager.sv @@
// ----------------------------------------------------------------------------
// reader_writer_lock_manager
// Writer-preferring reader-writer lock manager with an ordered waiter queue.
// ----------------------------------------------------------------------------
// Each input item is one request from one thread; the requester always gets
// the first result item and woken waiters follow in queue order, the final
// one flagged by out_last. Lock, try-lock and invalid requests are decided
// when accepted and finish through S_FIN. Unlock and withdraw walk the waiter
// queue held in a one-port-read RAM, one entry per cycle unless a grant finds
// staging full, reading ahead and compacting kept entries in place: a
// withdraw walks the queue once to drop the oldest entry of the requester
// and then, if one was dropped, may walk it again to wake waiters.
// No new item is taken until all results of the current one are staged; the
// last result may still sit in the output register while the next item is
// accepted. The queue RAM needs no clearing after reset: only entries below
// the fill count are ever read.
// ----------------------------------------------------------------------------
module reader_writer_lock_manager
  import rwlm_pkg::*;
#(
  parameter int MAX_WAITERS       = 16,
  parameter int THREAD_ID_BITS    = 8,
  parameter int READER_COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [2:0]                in_command,
  input  logic [THREAD_ID_BITS-1:0] in_thread_id,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [THREAD_ID_BITS-1:0] out_thread_id_res,
  output logic [2:0]                out_status,
  output logic                      out_last
);

  localparam int IDX_W = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int LEN_W = $clog2(MAX_WAITERS + 1);
  localparam int ENT_W = THREAD_ID_BITS + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRIME = 3'd1;
  localparam logic [2:0] S_PROC  = 3'd2;
  localparam logic [2:0] S_WEND  = 3'd3;
  localparam logic [2:0] S_WAKE  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  localparam logic [1:0] M_WITHDRAW = 2'd0;
  localparam logic [1:0] M_WAKE_WR  = 2'd1;
  localparam logic [1:0] M_WAKE_RD  = 2'd2;

  logic [2:0]                   state_r, state_nxt;
  logic [1:0]                   mode_r, mode_nxt;
  logic [THREAD_ID_BITS-1:0]    owner_r, owner_nxt;
  logic [READER_COUNT_BITS-1:0] rc_r, rc_nxt;
  logic [LEN_W-1:0]             wwc_r, wwc_nxt;
  logic [LEN_W-1:0]             qlen_r, qlen_nxt;
  logic [IDX_W-1:0]             p_r, p_nxt;
  logic [LEN_W-1:0]             j_r, j_nxt;
  logic                         found_r, found_nxt;
  logic [THREAD_ID_BITS-1:0]    tid_r, tid_nxt;

  logic                         ram_we;
  logic [IDX_W-1:0]             ram_waddr, ram_raddr;
  logic [ENT_W-1:0]             ram_wdata, ram_rdata;

  rwlm_emit_t                   emit;
  logic [THREAD_ID_BITS-1:0]    emit_tid;
  rwlm_room_t                   room;

  logic                         e_wr;
  logic [THREAD_ID_BITS-1:0]    e_tid;
  logic                         drop, adv, last_ent;
  logic                         rc_full;
  logic                         wr_req, try_req, ok;

  assign e_wr     = ram_rdata[ENT_W-1];
  assign e_tid    = ram_rdata[THREAD_ID_BITS-1:0];
  assign rc_full  = (rc_r == '1);
  assign last_ent = ((LEN_W'(p_r) + 1'b1) == qlen_r);
  assign in_stall = (state_r != S_IDLE);
  assign wr_req   = in_command[0];
  assign try_req  = in_command[1];
  assign ok       = wr_req ? (owner_r == '0 && rc_r == '0)
                           : (owner_r == '0 && wwc_r == '0);

  // Decide whether the entry at the head of the walk is dropped (granted
  // or withdrawn); kept entries slide down to the compaction pointer.
  always_comb begin
    drop = 1'b0;
    case (mode_r)
      M_WITHDRAW: drop = !found_r && (e_tid == tid_r);
      M_WAKE_WR:  drop = !found_r && e_wr;
      M_WAKE_RD:  drop = !e_wr && !rc_full;
      default:    drop = 1'b0;
    endcase
  end

  // Stall the walk only when a grant must go out and staging is full.
  assign adv = !(drop && (mode_r != M_WITHDRAW) && !room.room);

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    owner_nxt = owner_r;
    rc_nxt    = rc_r;
    wwc_nxt   = wwc_r;
    qlen_nxt  = qlen_r;
    p_nxt     = p_r;
    j_nxt     = j_r;
    found_nxt = found_r;
    tid_nxt   = tid_r;
    emit      = '0;
    emit_tid  = tid_r;
    ram_we    = 1'b0;
    ram_waddr = j_r[IDX_W-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = p_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tid_nxt   = in_thread_id;
          emit_tid  = in_thread_id;
          emit.push = 1'b1;
          state_nxt = S_FIN;
          if (in_thread_id == '0) begin
            emit.status = ST_AGAIN;
          end else begin
            case (in_command) inside
              CMD_READ, CMD_WRITE, CMD_TRY_READ, CMD_TRY_WRITE: begin
                if (ok) begin
                  if (wr_req) begin
                    owner_nxt   = in_thread_id;
                    emit.status = ST_GRANTED;
                  end else if (rc_full) begin
                    emit.status = ST_AGAIN;
                  end else begin
                    rc_nxt      = rc_r + 1'b1;
                    emit.status = ST_GRANTED;
                  end
                end else if (owner_r == in_thread_id) begin
                  emit.status = try_req ? ST_BUSY : ST_DEADLOCK;
                end else if (try_req) begin
                  emit.status = ST_BUSY;
                end else if (qlen_r == LEN_W'(MAX_WAITERS)) begin
                  emit.status = ST_AGAIN;
                end else begin
                  // append at the tail
                  ram_we      = 1'b1;
                  ram_waddr   = qlen_r[IDX_W-1:0];
                  ram_wdata   = {wr_req, in_thread_id};
                  qlen_nxt    = qlen_r + 1'b1;
                  if (wr_req) begin
                    wwc_nxt = wwc_r + 1'b1;
                  end
                  emit.status = ST_QUEUED;
                end
              end
              CMD_UNLOCK: begin
                if (owner_r == in_thread_id) begin
                  owner_nxt   = '0;
                  emit.status = ST_GRANTED;
                  state_nxt   = S_WAKE;
                end else if (rc_r != '0) begin
                  rc_nxt      = rc_r - 1'b1;
                  emit.status = ST_GRANTED;
                  state_nxt   = S_WAKE;
                end else begin
                  emit.status = ST_INVALID;
                end
              end
              CMD_WITHDRAW: begin
                if (qlen_r == '0) begin
                  emit.status = ST_NOTWAITING;
                end else begin
                  // result goes out after the walk
                  emit.push = 1'b0;
                  mode_nxt  = M_WITHDRAW;
                  found_nxt = 1'b0;
                  p_nxt     = '0;
                  j_nxt     = '0;
                  state_nxt = S_PRIME;
                end
              end
              default: emit.status = ST_INVALID;
            endcase
          end
        end
      end
      S_PRIME: begin
        state_nxt = S_PROC;
      end
      S_PROC: begin
        if (adv) begin
          ram_raddr = last_ent ? '0 : p_r + 1'b1;
          p_nxt     = p_r + 1'b1;
          if (drop) begin
            found_nxt = 1'b1;
            case (mode_r)
              M_WITHDRAW: begin
                if (e_wr) begin
                  wwc_nxt = wwc_r - 1'b1;
                end
              end
              M_WAKE_WR: begin
                owner_nxt   = e_tid;
                wwc_nxt     = wwc_r - 1'b1;
                emit.push   = 1'b1;
                emit.status = ST_GRANTED;
                emit_tid    = e_tid;
              end
              default: begin
                rc_nxt      = rc_r + 1'b1;
                emit.push   = 1'b1;
                emit.status = ST_GRANTED;
                emit_tid    = e_tid;
              end
            endcase
          end else begin
            ram_we = 1'b1;
            j_nxt  = j_r + 1'b1;
          end
          if (last_ent) begin
            qlen_nxt  = j_nxt;
            state_nxt = (mode_r == M_WITHDRAW) ? S_WEND : S_FIN;
          end
        end
      end
      S_WEND: begin
        emit.push = 1'b1;
        if (found_r) begin
          emit.status = ST_TIMEDOUT;
          state_nxt   = S_WAKE;
        end else begin
          emit.status = ST_NOTWAITING;
          state_nxt   = S_FIN;
        end
      end
      S_WAKE: begin
        found_nxt = 1'b0;
        p_nxt     = '0;
        j_nxt     = '0;
        state_nxt = S_FIN;
        if (owner_r == '0 && qlen_r != '0) begin
          if (rc_r == '0 && wwc_r != '0) begin
            mode_nxt  = M_WAKE_WR;
            state_nxt = S_PRIME;
          end else if (wwc_r == '0) begin
            mode_nxt  = M_WAKE_RD;
            state_nxt = S_PRIME;
          end
        end
      end
      S_FIN: begin
        emit.flush = 1'b1;
        if (room.free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_WITHDRAW;
      owner_r <= '0;
      rc_r    <= '0;
      wwc_r   <= '0;
      qlen_r  <= '0;
      found_r <= 1'b0;
      p_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      owner_r <= owner_nxt;
      rc_r    <= rc_nxt;
      wwc_r   <= wwc_nxt;
      qlen_r  <= qlen_nxt;
      found_r <= found_nxt;
      p_r     <= p_nxt;
      j_r     <= j_nxt;
    end
    tid_r <= tid_nxt;
  end

  rwlm_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WAITERS)
  ) u_queue (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  rwlm_out #(
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .emit              (emit),
    .emit_tid          (emit_tid),
    .room              (room),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_thread_id_res (out_thread_id_res),
    .out_status        (out_status),
    .out_last          (out_last)
  );

  a_wwc_le_len: assert property (@(posedge clk) disable iff (!rst_n)
    wwc_r <= qlen_r) else $error("waiting writers exceed queue length");

  a_len_max: assert property (@(posedge clk) disable iff (!rst_n)
    qlen_r <= LEN_W'(MAX_WAITERS)) else $error("queue length overflow");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(owner_r != '0 && rc_r != '0)) else $error("writer and readers together");

  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROC && ram_we) |-> (j_r <= LEN_W'(p_r)))
    else $error("compaction write ahead of read");

endmodule
